/* design/cst_pkg.sv */
// ============================================================================
// cst_pkg: shared types, constants and the byte judge of the comment stripper
// Holds the comment-mode codes, the character codes the lexer looks for, the
// result and bundle types, and the function that judges one byte.
// ============================================================================
`default_nettype none

package cst_pkg;

    localparam int unsigned MAX_RESULTS = 4;

    // Comment modes
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_LINE  = 2'd1;
    localparam logic [1:0] MODE_BLOCK = 2'd2;
    localparam logic [1:0] MODE_DROP  = 2'd3;

    // Characters of interest
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef struct packed {
        logic [7:0] ch;
        logic       start;
        logic       eos;
    } cst_res_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       in_tok;
        logic       nul;
    } cst_lex_t;

    typedef struct packed {
        cst_lex_t lex;
        logic     emit;
        cst_res_t res;
    } cst_judge_t;

    // Results of one accepted beat, handed from the lexer to the output stage.
    typedef struct packed {
        logic                      push;
        logic [2:0]                count;
        cst_res_t [MAX_RESULTS-1:0] res;
    } cst_bundle_t;

    localparam cst_lex_t LEX_RESET = '{mode: MODE_NONE, in_tok: 1'b0, nul: 1'b0};

    // Judge byte c with lookahead n1, n2; a disabled judge leaves the state alone.
    function automatic cst_judge_t cst_judge(cst_lex_t st, logic en, logic [7:0] c,
                                             logic [7:0] n1, logic [7:0] n2);
        cst_judge_t r;
        logic [1:0] m;
        r      = '0;
        r.lex  = st;
        m      = st.mode;
        if (en)
        begin
            if (m == MODE_DROP)
            begin
                r.lex.mode = MODE_NONE;
            end
            else
            begin
                if (c == CH_SLASH)
                begin
                    if (n1 == CH_SLASH && n2 != CH_HASH && m == MODE_NONE)
                        m = MODE_LINE;
                    else if (n1 == CH_STAR && m == MODE_NONE)
                        m = MODE_BLOCK;
                end
                else if (c == CH_STAR)
                begin
                    if (n1 == CH_SLASH && m == MODE_BLOCK)
                        m = MODE_DROP;
                end
                else if (c == CH_LF)
                begin
                    if (m == MODE_LINE)
                        m = MODE_NONE;
                end
                r.lex.mode = m;
                if (m == MODE_NONE && !st.nul)
                begin
                    if (c == CH_NUL)
                    begin
                        r.lex.nul = 1'b1;
                    end
                    else if (c == CH_SPACE || c == CH_LF || c == CH_TAB || c == CH_CR)
                    begin
                        r.lex.in_tok = 1'b0;
                    end
                    else if (c == CH_COLON)
                    begin
                        r.emit       = 1'b1;
                        r.res        = '{ch: c, start: 1'b1, eos: 1'b0};
                        r.lex.in_tok = 1'b0;
                    end
                    else
                    begin
                        r.emit       = 1'b1;
                        r.res        = '{ch: c, start: !st.in_tok, eos: 1'b0};
                        r.lex.in_tok = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/cst_in_if.sv */
// ============================================================================
// cst_in_if: raw text channel
// Carries one text byte per beat and a flag on the final byte of the text.
// ============================================================================
`default_nettype none

interface cst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       last_char;

    modport source (output valid, output in_char, output last_char, input ready);
    modport sink   (input valid, input in_char, input last_char, output ready);
endinterface

`default_nettype wire

/* design/cst_out_if.sv */
// ============================================================================
// cst_out_if: token byte channel
// Carries one token byte per beat, its token-start flag and the end marker.
// ============================================================================
`default_nettype none

interface cst_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       token_start;
    logic       end_of_stream;

    modport source (output valid, output out_char, output token_start,
                    output end_of_stream, input ready);
    modport sink   (input valid, input out_char, input token_start,
                    input end_of_stream, output ready);
endinterface

`default_nettype wire

/* design/cst_lexer.sv */
// ============================================================================
// cst_lexer: lookahead buffer, comment state and tokenizer
// Keeps two bytes of lookahead and judges at most one byte per beat; on the final
// byte it flushes the buffer and appends the end marker.
// ============================================================================
`default_nettype none

module cst_lexer (
    input  wire logic           clk,
    input  wire logic           rst_n,
    cst_in_if.sink              text,
    input  wire logic           push_ready,
    output cst_pkg::cst_bundle_t bundle
);
    import cst_pkg::*;

    logic [7:0] la0_reg, la0_next;
    logic [7:0] la1_reg, la1_next;
    logic [1:0] cnt_reg, cnt_next;
    cst_lex_t   lex_reg, lex_next;

    logic       accept;
    logic [7:0] s0, s1, s2;
    logic [2:0] en;
    cst_judge_t j0, j1, j2;
    logic [2:0] k;

    assign text.ready = push_ready;
    assign accept     = text.valid && push_ready;

    // Byte sequence to judge; anything past the end of the text reads as NUL.
    always_comb
    begin
        s0 = la0_reg;
        s1 = la1_reg;
        s2 = text.in_char;
        en = 3'b000;
        unique case (cnt_reg)
            2'd0:
            begin
                s0 = text.in_char;
                s1 = CH_NUL;
                s2 = CH_NUL;
                en = text.last_char ? 3'b001 : 3'b000;
            end
            2'd1:
            begin
                s1 = text.in_char;
                s2 = CH_NUL;
                en = text.last_char ? 3'b011 : 3'b000;
            end
            default:
            begin
                en = text.last_char ? 3'b111 : 3'b001;
            end
        endcase
    end

    assign j0 = cst_judge(lex_reg, en[0], s0, s1, s2);
    assign j1 = cst_judge(j0.lex, en[1], s1, s2, CH_NUL);
    assign j2 = cst_judge(j1.lex, en[2], s2, CH_NUL, CH_NUL);

    // Pack the emitted bytes in order, then the end marker on the final byte.
    always_comb
    begin
        bundle.res = '0;
        k          = 3'd0;
        if (j0.emit)
        begin
            bundle.res[k[1:0]] = j0.res;
            k                  = k + 3'd1;
        end
        if (j1.emit)
        begin
            bundle.res[k[1:0]] = j1.res;
            k                  = k + 3'd1;
        end
        if (j2.emit)
        begin
            bundle.res[k[1:0]] = j2.res;
            k                  = k + 3'd1;
        end
        if (text.last_char)
        begin
            bundle.res[k[1:0]] = '{ch: CH_NUL, start: 1'b0, eos: 1'b1};
            k                  = k + 3'd1;
        end
        bundle.count = k;
        bundle.push  = accept && (k != 3'd0);
    end

    always_comb
    begin
        la0_next = la0_reg;
        la1_next = la1_reg;
        cnt_next = cnt_reg;
        lex_next = lex_reg;
        if (accept)
        begin
            if (text.last_char)
            begin
                cnt_next = 2'd0;
                lex_next = LEX_RESET;
            end
            else if (cnt_reg == 2'd0)
            begin
                la0_next = text.in_char;
                cnt_next = 2'd1;
            end
            else if (cnt_reg == 2'd1)
            begin
                la1_next = text.in_char;
                cnt_next = 2'd2;
            end
            else
            begin
                la0_next = la1_reg;
                la1_next = text.in_char;
                lex_next = j0.lex;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            lex_reg <= LEX_RESET;
        end
        else
        begin
            cnt_reg <= cnt_next;
            lex_reg <= lex_next;
        end
    end

    always_ff @(posedge clk)
    begin
        la0_reg <= la0_next;
        la1_reg <= la1_next;
    end

endmodule

`default_nettype wire

/* design/cst_outq.sv */
// ============================================================================
// cst_outq: result register and serializer
// Holds the results of one beat and hands them out one per output beat.
// ============================================================================
`default_nettype none

module cst_outq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  cst_pkg::cst_bundle_t bundle,
    output logic                push_ready,
    cst_out_if.source           tokens
);
    import cst_pkg::*;

    cst_res_t [MAX_RESULTS-1:0] ent_reg, ent_next;
    logic [2:0]                 rem_reg, rem_next;
    logic [1:0]                 idx_reg, idx_next;
    logic                       pop;

    assign tokens.valid         = (rem_reg != 3'd0);
    assign tokens.out_char      = ent_reg[idx_reg].ch;
    assign tokens.token_start   = ent_reg[idx_reg].start;
    assign tokens.end_of_stream = ent_reg[idx_reg].eos;

    assign pop        = tokens.valid && tokens.ready;
    // A new bundle may load as the last held result leaves.
    assign push_ready = (rem_reg == 3'd0) || (rem_reg == 3'd1 && pop);

    always_comb
    begin
        ent_next = ent_reg;
        rem_next = rem_reg;
        idx_next = idx_reg;
        if (bundle.push)
        begin
            ent_next = bundle.res;
            rem_next = bundle.count;
            idx_next = 2'd0;
        end
        else if (pop)
        begin
            rem_next = rem_reg - 3'd1;
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 3'd0;
            idx_reg <= 2'd0;
        end
        else
        begin
            rem_reg <= rem_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

`default_nettype wire

/* design/comment_strip_tokenizer.sv */
// ============================================================================
// comment_strip_tokenizer: comment-stripping lexer, top level
//
//   channel   role   beat payload
//   text      sink   in_char, last_char
//   tokens    source out_char, token_start, end_of_stream
//
// One text byte is taken per cycle while the result register has room;
// each byte yields at most one token byte, two bytes behind the input
// because of the lookahead buffer. The final byte yields up to four beats
// (flushed bytes plus the end marker), which the result register hands out
// one per output beat; text.ready is low until the last of them leaves.
// Reset clears the comment state, the lookahead count and the result count.
// A stall on tokens holds text.ready low once the result register is full.
// ============================================================================
`default_nettype none

module comment_strip_tokenizer (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cst_in_if.sink      text,
    cst_out_if.source   tokens
);
    import cst_pkg::*;

    cst_bundle_t bundle;
    logic        push_ready;

    cst_lexer u_lexer (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .push_ready (push_ready),
        .bundle     (bundle)
    );

    cst_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .bundle     (bundle),
        .push_ready (push_ready),
        .tokens     (tokens)
    );

endmodule

`default_nettype wire

/* test/token_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// token_checker: prediction and comparison for the comment-stripping lexer
// Watches the text and token channels. Each accepted text beat runs through
// a local model of the lexer (comment state, two-byte lookahead, token
// state), and the predicted token beats queue up in order. Each accepted
// token beat is checked field by field against the oldest prediction.
// ============================================================================
module token_checker (
    input  logic        clk,
    input  logic        rst_n,
    cst_in_if           text,
    cst_out_if          tokens,
    output int unsigned fail_count,
    output int unsigned pending,
    output int unsigned token_beats,
    output int unsigned end_markers
);
    import cst_pkg::*;

    cst_res_t    expected_tokens[$];
    logic [1:0]  strip_mode;
    logic [7:0]  ahead [0:1];
    int unsigned ahead_cnt;
    logic        in_token;
    logic        nul_hit;
    int unsigned fails;
    int unsigned beats;
    int unsigned ends;

    task automatic clear_lexer();
        strip_mode = MODE_NONE;
        ahead[0]   = CH_NUL;
        ahead[1]   = CH_NUL;
        ahead_cnt  = 0;
        in_token   = 1'b0;
        nul_hit    = 1'b0;
    endtask

    task automatic expect_token(input logic [7:0] c, input logic first, input logic eos);
        cst_res_t r;
        r.ch    = c;
        r.start = first;
        r.eos   = eos;
        expected_tokens.insert(expected_tokens.size(), r);
    endtask

    task automatic split_byte(input logic [7:0] c);
        if (!nul_hit)
        begin
            if (c == CH_NUL)
                nul_hit = 1'b1;
            else if (c == CH_SPACE || c == CH_LF || c == CH_TAB || c == CH_CR)
                in_token = 1'b0;
            else if (c == CH_COLON)
            begin
                expect_token(c, 1'b1, 1'b0);
                in_token = 1'b0;
            end
            else
            begin
                expect_token(c, !in_token, 1'b0);
                in_token = 1'b1;
            end
        end
    endtask

    // Decide whether byte c survives, looking at the two bytes after it.
    task automatic strip_byte(input logic [7:0] c, input logic [7:0] n1, input logic [7:0] n2);
        if (strip_mode == MODE_DROP)
            strip_mode = MODE_NONE;
        else
        begin
            if (c == CH_SLASH)
            begin
                if (n1 == CH_SLASH && n2 != CH_HASH && strip_mode == MODE_NONE)
                    strip_mode = MODE_LINE;
                if (n1 == CH_STAR && strip_mode == MODE_NONE)
                    strip_mode = MODE_BLOCK;
            end
            else if (c == CH_STAR)
            begin
                if (n1 == CH_SLASH && strip_mode == MODE_BLOCK)
                    strip_mode = MODE_DROP;
            end
            else if (c == CH_LF)
            begin
                if (strip_mode == MODE_LINE)
                    strip_mode = MODE_NONE;
            end
            if (strip_mode == MODE_NONE)
                split_byte(c);
        end
    endtask

    task automatic take_text_byte(input logic [7:0] c, input logic fin);
        logic [7:0]  seq [0:4];
        int unsigned len;
        int unsigned i;
        if (!fin)
        begin
            if (ahead_cnt < 2)
            begin
                ahead[ahead_cnt] = c;
                ahead_cnt++;
            end
            else
            begin
                strip_byte(ahead[0], ahead[1], c);
                ahead[0] = ahead[1];
                ahead[1] = c;
            end
        end
        else
        begin
            // Final byte: flush the lookahead with NUL past the end of the text.
            len = 0;
            for (i = 0; i < ahead_cnt; i++)
            begin
                seq[len] = ahead[i];
                len++;
            end
            seq[len]     = c;
            len++;
            seq[len]     = CH_NUL;
            seq[len + 1] = CH_NUL;
            for (i = 0; i < len; i++)
                strip_byte(seq[i], seq[i + 1], seq[i + 2]);
            expect_token(CH_NUL, 1'b0, 1'b1);
            clear_lexer();
        end
    endtask

    task automatic check_token_beat();
        cst_res_t got;
        cst_res_t want;
        got.ch    = tokens.out_char;
        got.start = tokens.token_start;
        got.eos   = tokens.end_of_stream;
        if (expected_tokens.size() == 0)
        begin
            fails++;
            $display("%0t: token beat with nothing expected, expected none, got %02h/%b/%b",
                     $time, got.ch, got.start, got.eos);
        end
        else
        begin
            want = expected_tokens.pop_front();
            if (got.ch !== want.ch)
            begin
                fails++;
                $display("%0t: out_char mismatch, expected %02h, got %02h",
                         $time, want.ch, got.ch);
            end
            if (got.start !== want.start)
            begin
                fails++;
                $display("%0t: token_start mismatch on %02h, expected %b, got %b",
                         $time, want.ch, want.start, got.start);
            end
            if (got.eos !== want.eos)
            begin
                fails++;
                $display("%0t: end_of_stream mismatch, expected %b, got %b",
                         $time, want.eos, got.eos);
            end
            if (want.eos)
                ends++;
            else
                beats++;
        end
    endtask

    // Output beats are checked before the input beat of the same edge is
    // predicted, since no token beat can come from a byte taken at that edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_lexer();
            expected_tokens.delete();
            fails       = 0;
            beats       = 0;
            ends        = 0;
            fail_count  <= 0;
            pending     <= 0;
            token_beats <= 0;
            end_markers <= 0;
        end
        else
        begin
            if (tokens.valid && tokens.ready)
                check_token_beat();
            if (text.valid && text.ready)
                take_text_byte(text.in_char, text.last_char);
            fail_count  <= fails;
            pending     <= expected_tokens.size();
            token_beats <= beats;
            end_markers <= ends;
        end
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench: stimulus and verdict for comment_strip_tokenizer
// Sends a few hand-written texts that hit the comment and token corner cases,
// then random texts built mostly from words, line and block comments,
// directive slashes and colons, with noise mixed in. Both channels idle at
// random, and the token side once holds off long enough to stall the text
// side. A separate checker predicts and compares every token beat.
// ============================================================================
module testbench;
    import cst_pkg::*;

    localparam int unsigned RANDOM_BYTES = 240;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned HOLD_AFTER   = 120;
    localparam int unsigned TIMEOUT_NS   = 1000000;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned token_beats;
    int unsigned end_markers;
    int unsigned bytes_sent = 0;
    int unsigned texts_sent = 0;
    bit          hold_done  = 1'b0;
    logic [7:0]  text_buf[$];

    cst_in_if  text_ch ();
    cst_out_if token_ch ();

    comment_strip_tokenizer uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .tokens (token_ch)
    );

    token_checker tok_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .text        (text_ch),
        .tokens      (token_ch),
        .fail_count  (fail_count),
        .pending     (pending),
        .token_beats (token_beats),
        .end_markers (end_markers)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mostly back to back, sometimes a short gap, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] word_byte();
        if ($urandom_range(0, 3) != 0)
            return 8'(8'h61 + $urandom_range(0, 25));
        else
            return 8'(8'h30 + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] separator_byte();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] noise_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return word_byte();
        else if (r < 50)
            return separator_byte();
        else if (r < 57)
            return CH_COLON;
        else if (r < 67)
            return CH_SLASH;
        else if (r < 75)
            return CH_STAR;
        else if (r < 80)
            return CH_HASH;
        else if (r < 99)
            return 8'($urandom_range(1, 255));
        else
            return CH_NUL;
    endfunction

    task automatic append_byte(input logic [7:0] c);
        text_buf.insert(text_buf.size(), c);
    endtask

    task automatic add_segment();
        int unsigned r;
        int unsigned n;
        int unsigned k;
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++)
                append_byte(word_byte());
            append_byte(separator_byte());
        end
        else if (r < 45)
        begin
            append_byte(CH_SLASH);
            append_byte(CH_SLASH);
            n = $urandom_range(0, 6);
            for (k = 0; k < n; k++)
                append_byte(noise_byte());
            append_byte(CH_LF);
        end
        else if (r < 60)
        begin
            append_byte(CH_SLASH);
            append_byte(CH_STAR);
            n = $urandom_range(0, 6);
            for (k = 0; k < n; k++)
                append_byte(noise_byte());
            append_byte(CH_STAR);
            append_byte(CH_SLASH);
        end
        else if (r < 65)
        begin
            // The star of the opener also closes: a complete comment.
            append_byte(CH_SLASH);
            append_byte(CH_STAR);
            append_byte(CH_SLASH);
        end
        else if (r < 72)
        begin
            append_byte(CH_SLASH);
            append_byte(CH_SLASH);
            append_byte(CH_HASH);
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++)
                append_byte(word_byte());
        end
        else if (r < 80)
            append_byte(CH_COLON);
        else
        begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++)
                append_byte(noise_byte());
        end
    endtask

    task automatic build_random_text();
        int unsigned n;
        int unsigned k;
        text_buf.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 2);
            for (k = 0; k < n; k++)
                append_byte(noise_byte());
        end
        else
        begin
            n = $urandom_range(1, 5);
            for (k = 0; k < n; k++)
                add_segment();
        end
    endtask

    task automatic send_byte(input logic [7:0] c, input logic fin, input bit no_gap);
        int unsigned gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap != 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.in_char   <= c;
        text_ch.last_char <= fin;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text();
        int unsigned i;
        bit          burst;
        burst = ($urandom_range(0, 3) == 0);
        for (i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1, burst);
        texts_sent++;
    endtask

    // Token side: runs of ready, short stalls, and one long hold-off that
    // fills the block while the text side keeps offering beats.
    initial
    begin
        token_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            token_ch.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(20, 60)) @(posedge clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
            if (!hold_done && bytes_sent >= HOLD_AFTER)
            begin
                token_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if ($urandom_range(0, 2) != 0)
            begin
                token_ch.ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge clk);
            end
        end
    end

    initial
    begin
        int unsigned directed_bytes;
        rst_n             <= 1'b0;
        text_ch.valid     <= 1'b0;
        text_ch.in_char   <= CH_NUL;
        text_ch.last_char <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single top-value byte: the final beat alone flushes it.
        text_buf = '{8'hFF};
        send_text();
        // Block comment closed by the star of its own opener.
        text_buf = '{CH_SLASH, CH_STAR, CH_SLASH, "q", CH_STAR, CH_SLASH, CH_COLON};
        send_text();
        // Directive slashes kept, then a line comment that keeps its newline.
        text_buf = '{CH_SLASH, CH_SLASH, CH_HASH, "x", CH_TAB, "y", CH_SLASH, CH_SLASH,
                     "z", CH_LF, "w"};
        send_text();
        // A surviving NUL ends tokenizing for the rest of the text.
        text_buf = '{"a", CH_CR, CH_NUL, "b"};
        send_text();
        directed_bytes = bytes_sent;

        while (bytes_sent < directed_bytes + RANDOM_BYTES)
        begin
            build_random_text();
            send_text();
        end
        text_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        if (pending != 0)
            $display("%0t: %0d expected token beats never arrived", $time, pending);
        $display("Run covered %0d text bytes in %0d texts; %0d token beats and %0d end markers",
                 bytes_sent, texts_sent, token_beats, end_markers);
        $display("were compared: both comment kinds, colons, NUL cutoff and a long stall.");
        if (fail_count == 0 && pending == 0)
            $display("comment_strip_tokenizer test passed");
        else
            $display("comment_strip_tokenizer test failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("%0t: timeout with %0d token beats still expected", $time, pending);
        $display("comment_strip_tokenizer test failed");
        $finish;
    end

endmodule

/* sim.f */
design/cst_pkg.sv
design/cst_in_if.sv
design/cst_out_if.sv
design/cst_lexer.sv
design/cst_outq.sv
design/comment_strip_tokenizer.sv
test/token_checker.sv
test/testbench.sv
